FILE: rtl/core/smva_pkg.sv
// Shared constants, step codes and control structs of the signed mesh volume accumulator.
package smva_pkg;

    localparam int FRAC_BITS = 32;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int OPND_W    = HALF_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 2 * WORD_W;
    localparam int IN_W      = 9 * WORD_W;

    // floor(2^FRAC_BITS / 6)
    localparam logic [WORD_W-1:0] SIXTH = WORD_W'((ACC_W'(1) << FRAC_BITS) / 6);

    localparam int STEP_W = 4;

    // Multiplication schedule for one triangle
    localparam logic [STEP_W-1:0] M_CX_P  = 4'd0;  // t0  = v1y * v2z
    localparam logic [STEP_W-1:0] M_CX_N  = 4'd1;  // cx  = t0 - v1z * v2y
    localparam logic [STEP_W-1:0] M_CY_P  = 4'd2;  // t0  = v1z * v2x
    localparam logic [STEP_W-1:0] M_CY_N  = 4'd3;  // cy  = t0 - v1x * v2z
    localparam logic [STEP_W-1:0] M_CZ_P  = 4'd4;  // t0  = v1x * v2y
    localparam logic [STEP_W-1:0] M_CZ_N  = 4'd5;  // cz  = t0 - v1y * v2x
    localparam logic [STEP_W-1:0] M_DOT_X = 4'd6;  // dot = v0x * cx
    localparam logic [STEP_W-1:0] M_DOT_Y = 4'd7;  // dot += v0y * cy
    localparam logic [STEP_W-1:0] M_DOT_Z = 4'd8;  // dot += v0z * cz
    localparam logic [STEP_W-1:0] M_SCALE = 4'd9;  // sum += dot * SIXTH

    // Partial product order: ll, lh, hl, hh
    localparam logic [1:0] PP_LAST = 2'd3;

    typedef struct packed {
        logic                load;
        logic                pp_issue;
        logic [1:0]          pp_idx;
        logic                wb;
        logic [STEP_W-1:0]   step;
        logic                emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_stat_t;

endpackage

FILE: rtl/core/smva_datapath.sv
// Datapath: operand latches, shared 33x33 multiplier, product accumulator and running sum.
module smva_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smva_pkg::dp_cmd_t             cmd,
    output smva_pkg::dp_stat_t            stat,
    input  logic [smva_pkg::IN_W-1:0]     in_data,
    input  logic                          in_last,
    output logic [smva_pkg::WORD_W-1:0]   out_data
);
    import smva_pkg::*;

    logic [WORD_W-1:0] v_reg [9];
    logic              last_reg;

    logic [WORD_W-1:0] t0_reg, cx_reg, cy_reg, cz_reg, dot_reg, sum_reg, out_reg;

    logic [WORD_W-1:0] op_a, op_b;
    logic signed [OPND_W-1:0] pa, pb;
    logic signed [PROD_W-1:0] prod;

    logic signed [PROD_W-1:0] pp_reg;
    logic [1:0]               pp_sh_reg;
    logic                     pp_vld_reg;
    logic                     pp_first_reg;

    logic [ACC_W-1:0] acc_reg, acc_next, pp_ext, pp_shifted;
    logic [WORD_W-1:0] res, sum_new;

    // Operand selection per schedule step
    always_comb
    begin
        op_a = v_reg[4];
        op_b = v_reg[8];
        case (cmd.step)
            M_CX_P:  begin op_a = v_reg[4]; op_b = v_reg[8]; end
            M_CX_N:  begin op_a = v_reg[5]; op_b = v_reg[7]; end
            M_CY_P:  begin op_a = v_reg[5]; op_b = v_reg[6]; end
            M_CY_N:  begin op_a = v_reg[3]; op_b = v_reg[8]; end
            M_CZ_P:  begin op_a = v_reg[3]; op_b = v_reg[7]; end
            M_CZ_N:  begin op_a = v_reg[4]; op_b = v_reg[6]; end
            M_DOT_X: begin op_a = v_reg[0]; op_b = cx_reg;   end
            M_DOT_Y: begin op_a = v_reg[1]; op_b = cy_reg;   end
            M_DOT_Z: begin op_a = v_reg[2]; op_b = cz_reg;   end
            M_SCALE: begin op_a = dot_reg;  op_b = SIXTH;    end
            default: begin op_a = v_reg[4]; op_b = v_reg[8]; end
        endcase
    end

    // High halves carry the sign, low halves are zero-extended
    always_comb
    begin
        if (cmd.pp_idx[1])
            pa = {op_a[WORD_W-1], op_a[WORD_W-1:HALF_W]};
        else
            pa = {1'b0, op_a[HALF_W-1:0]};
        if (cmd.pp_idx[0])
            pb = {op_b[WORD_W-1], op_b[WORD_W-1:HALF_W]};
        else
            pb = {1'b0, op_b[HALF_W-1:0]};
        prod = pa * pb;
    end

    always_comb
    begin
        pp_ext = {{(ACC_W-PROD_W){pp_reg[PROD_W-1]}}, pp_reg};
        case (pp_sh_reg)
            2'd0:    pp_shifted = pp_ext;
            2'd1:    pp_shifted = pp_ext << HALF_W;
            2'd2:    pp_shifted = pp_ext << WORD_W;
            default: pp_shifted = pp_ext;
        endcase
        acc_next = (pp_first_reg ? '0 : acc_reg) + pp_shifted;
    end

    assign res     = acc_reg[FRAC_BITS+WORD_W-1 -: WORD_W];
    assign sum_new = sum_reg + res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pp_vld_reg <= 1'b0;
            sum_reg    <= '0;
        end
        else
        begin
            pp_vld_reg <= cmd.pp_issue;
            if (cmd.wb && cmd.step == M_SCALE)
                sum_reg <= cmd.emit ? '0 : sum_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 9; i++)
                v_reg[i] <= in_data[i*WORD_W +: WORD_W];
            last_reg <= in_last;
        end
        if (cmd.pp_issue)
        begin
            pp_reg       <= prod;
            pp_sh_reg    <= 2'(cmd.pp_idx[0]) + 2'(cmd.pp_idx[1]);
            pp_first_reg <= (cmd.pp_idx == 2'd0);
        end
        if (pp_vld_reg)
            acc_reg <= acc_next;
        if (cmd.wb)
        begin
            case (cmd.step)
                M_CX_P, M_CY_P, M_CZ_P: t0_reg <= res;
                M_CX_N:  cx_reg  <= t0_reg - res;
                M_CY_N:  cy_reg  <= t0_reg - res;
                M_CZ_N:  cz_reg  <= t0_reg - res;
                M_DOT_X: dot_reg <= res;
                M_DOT_Y, M_DOT_Z: dot_reg <= dot_reg + res;
                default: ;
            endcase
        end
        if (cmd.emit)
            out_reg <= sum_new;
    end

    assign stat.last = last_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/core/smva_ctrl.sv
// Controller: sequences the ten multiplications of a triangle and owns both handshakes.
module smva_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output smva_pkg::dp_cmd_t     cmd,
    input  smva_pkg::dp_stat_t    stat
);
    import smva_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        pp_reg, pp_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        pp_next    = pp_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.pp_idx = pp_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    pp_next    = '0;
                    step_next  = M_CX_P;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.pp_issue = 1'b1;
                pp_next      = pp_reg + 2'd1;
                if (pp_reg == PP_LAST)
                    state_next = ST_ADD;
            end
            ST_ADD:
                state_next = ST_WB;
            ST_WB:
            begin
                if (step_reg != M_SCALE)
                begin
                    cmd.wb     = 1'b1;
                    step_next  = step_reg + STEP_W'(1);
                    pp_next    = '0;
                    state_next = ST_MUL;
                end
                else if (!stat.last)
                begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // emit only once the output register frees up; otherwise hold in ST_WB
                    cmd.wb     = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        out_valid_next = cmd.emit | (out_valid_reg & ~m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pp_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pp_reg        <= pp_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

FILE: rtl/core/signed_mesh_volume_accumulator.sv
// Top level of the signed mesh volume accumulator.
// Takes one triangle per transaction (three Q32.32 vertices), adds the signed volume
// v0 . (v1 x v2) / 6 of its tetrahedron with the origin to a wrapping 64-bit sum, and on
// the transaction with tlast high sends the batch sum and clears it. A new triangle is
// taken only once the previous one is through: the idle state latches it, then ten 64x64
// fixed-point multiplications run one after another through a single 33x33 multiplier,
// each made of four partial products, an accumulate and a write-back. Ready stays low
// until the controller is back in idle. A finished sum sits in an output register, so the
// next triangle is taken while it waits; a batch end stalls only if the previous sum is
// still unread.
module signed_mesh_volume_accumulator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (64 bits each)
    input  logic [smva_pkg::IN_W-1:0]     s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // batch_volume (64 bits)
    output logic [smva_pkg::WORD_W-1:0]   m_tdata
);
    import smva_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    smva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    smva_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .out_data (m_tdata)
    );

endmodule

FILE: rtl/core/smva_checker.sv
// Port-level checker for the signed mesh volume accumulator, bound to the top level.
module smva_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [smva_pkg::WORD_W-1:0]   m_tdata
);
    import smva_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One triangle at a time: busy right after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a triangle is in progress");

    // A sum cannot appear the cycle after a triangle is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared before the triangle was processed");

endmodule

bind signed_mesh_volume_accumulator smva_checker u_smva_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/sv/signed_mesh_volume_accumulator_tb.sv
// Self-checking testbench of the signed mesh volume accumulator stream block.
`timescale 1ns / 100ps

module signed_mesh_volume_accumulator_tb;

    localparam int            CYCLE_LIMIT  = 600000;
    localparam int            DRAIN_CYCLES = 70;
    localparam int            RANDOM_FACES = 1850;
    localparam logic [63:0]   ONE_Q        = 64'h0000_0001_0000_0000;
    localparam logic [63:0]   MAX_Q        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]   MIN_Q        = 64'h8000_0000_0000_0000;
    localparam logic [63:0]   UNIT_VOLUME  = 64'd715827882;

    typedef logic [2:0][63:0] vec3_t;

    // Coordinates in transaction order: crd[0] is v0_x, crd[8] is v2_z
    typedef struct packed {
        logic [8:0][63:0] crd;
        logic             last;
        logic             typed;
        logic [63:0]      want;
    } face_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [smva_pkg::IN_W-1:0]          s_tdata;
    logic                               s_tlast;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [smva_pkg::WORD_W-1:0]        m_tdata;

    logic [63:0]    batch_sum;
    logic [63:0]    pending_sums [$];
    face_row_t      directed_rows [$];
    int             error_count;
    int             faces_sent;
    int             batches_closed;
    int             sums_checked;
    int             cycle_count;

    signed_mesh_volume_accumulator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Q32.32 product: full signed 128-bit product, arithmetic shift, low word kept
    function automatic logic [63:0] fx_product(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        logic signed [127:0] wide_a;
        logic signed [127:0] wide_b;
        logic signed [127:0] prod;
        wide_a = a;
        wide_b = b;
        prod   = (wide_a * wide_b) >>> smva_pkg::FRAC_BITS;
        return prod[63:0];
    endfunction

    function automatic logic [63:0] face_volume(input logic [8:0][63:0] c);
        logic [63:0] cx;
        logic [63:0] cy;
        logic [63:0] cz;
        logic [63:0] dot;
        cx  = fx_product(c[4], c[8]) - fx_product(c[5], c[7]);
        cy  = fx_product(c[5], c[6]) - fx_product(c[3], c[8]);
        cz  = fx_product(c[3], c[7]) - fx_product(c[4], c[6]);
        dot = fx_product(c[0], cx) + fx_product(c[1], cy) + fx_product(c[2], cz);
        return fx_product(dot, UNIT_VOLUME);
    endfunction

    function automatic vec3_t vec(input logic [63:0] x, input logic [63:0] y,
                                  input logic [63:0] z);
        return {z, y, x};
    endfunction

    function automatic face_row_t make_row(input vec3_t a, input vec3_t b, input vec3_t c,
                                           input logic last, input logic typed,
                                           input logic [63:0] want);
        face_row_t row;
        row.crd   = {c, b, a};
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic logic [63:0] rand_coord();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return raw;
            4, 5, 6:    return {{27{raw[36]}}, raw[36:0]};
            7:          return {{31{raw[32]}}, raw[32:0]};
            8:          return {{15{raw[48]}}, raw[48:0]};
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return MAX_Q;
                    1:       return MIN_Q;
                    2:       return '0;
                    3:       return '1;
                    4:       return ONE_Q;
                    default: return -ONE_Q;
                endcase
            end
        endcase
    endfunction

    function automatic face_row_t rand_face(input logic last);
        face_row_t row;
        for (int i = 0; i < 9; i++)
        begin
            row.crd[i] = rand_coord();
        end
        // Degenerate triangles: repeated vertex or vertex at the origin
        case ($urandom_range(0, 19))
            0: row.crd[8:6] = row.crd[5:3];
            1: row.crd[2:0] = '0;
            default: ;
        endcase
        row.last  = last;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_face(input face_row_t row, input int gap);
        logic [63:0] vol;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.crd;
        s_tlast  <= row.last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        vol       = face_volume(row.crd);
        batch_sum = batch_sum + vol;
        faces_sent++;
        if (row.last)
        begin
            pending_sums.push_back(row.typed ? row.want : batch_sum);
            batch_sum = '0;
            batches_closed++;
        end
    endtask

    // Cycle budget
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d sums outstanding",
                     cycle_count, pending_sums.size());
            $display("signed_mesh_volume_accumulator regression: fail");
            $finish;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_sums.size() == 0)
            begin
                report_mismatch("unexpected batch_volume", m_tdata, 'x);
            end
            else
            begin
                if (m_tdata !== pending_sums[0])
                begin
                    report_mismatch("batch_volume", m_tdata, pending_sums[0]);
                end
                void'(pending_sums.pop_front());
                sums_checked++;
            end
        end
    end

    // Receiver: stall a random number of cycles before each result
    initial
    begin : receiver
        int  stall;
        int  taken;
        bit  eager;
        m_tready = 1'b0;
        taken    = 0;
        eager    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
            begin
                eager = ($urandom_range(0, 3) == 0);
            end
            stall = eager ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            taken++;
        end
    end

    initial
    begin : stimulus
        int  gap;
        int  left_in_batch;
        bit  burst;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        rst_n          = 1'b0;
        batch_sum      = '0;
        error_count    = 0;
        faces_sent     = 0;
        batches_closed = 0;
        sums_checked   = 0;
        cycle_count    = 0;

        // Zero sum after reset, then unit tetrahedra of both orientations
        directed_rows.push_back(make_row(vec(0, 0, 0), vec(0, 0, 0), vec(0, 0, 0),
                                         1'b1, 1'b1, '0));
        directed_rows.push_back(make_row(vec(ONE_Q, 0, 0), vec(0, ONE_Q, 0),
                                         vec(0, 0, ONE_Q), 1'b1, 1'b1, UNIT_VOLUME));
        directed_rows.push_back(make_row(vec(ONE_Q, 0, 0), vec(0, 0, ONE_Q),
                                         vec(0, ONE_Q, 0), 1'b1, 1'b1, -UNIT_VOLUME));
        // Three-triangle batch
        for (int i = 0; i < 3; i++)
        begin
            directed_rows.push_back(make_row(vec(ONE_Q, 0, 0), vec(0, ONE_Q, 0),
                                             vec(0, 0, ONE_Q), i == 2, i == 2,
                                             3 * UNIT_VOLUME));
        end
        // Batch closed by a degenerate triangle
        directed_rows.push_back(make_row(vec(0, ONE_Q, 0), vec(0, 0, ONE_Q),
                                         vec(ONE_Q, 0, 0), 1'b0, 1'b0, '0));
        directed_rows.push_back(make_row(vec(ONE_Q, ONE_Q, 0), vec(ONE_Q, ONE_Q, 0),
                                         vec(0, 0, ONE_Q), 1'b1, 1'b1, UNIT_VOLUME));
        // Field extremes and wrapping
        directed_rows.push_back(make_row(vec(MAX_Q, MAX_Q, MAX_Q), vec(MAX_Q, MAX_Q, MAX_Q),
                                         vec(MAX_Q, MAX_Q, MAX_Q), 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(vec(MIN_Q, MIN_Q, MIN_Q), vec(MIN_Q, MIN_Q, MIN_Q),
                                         vec(MIN_Q, MIN_Q, MIN_Q), 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(vec(MAX_Q, MIN_Q, MAX_Q), vec(MIN_Q, MAX_Q, MIN_Q),
                                         vec(MAX_Q, MAX_Q, MIN_Q), 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(vec(MIN_Q, MAX_Q, 0), vec(MAX_Q, 0, MIN_Q),
                                         vec(0, MIN_Q, MAX_Q), 1'b0, 1'b0, '0));
        directed_rows.push_back(make_row(vec(MAX_Q, ONE_Q, MIN_Q), vec(ONE_Q, MAX_Q, ONE_Q),
                                         vec(MIN_Q, -ONE_Q, MAX_Q), 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(vec('1, '1, '1), vec('1, '1, '1),
                                         vec('1, '1, '1), 1'b1, 1'b0, '0));
        // Alternating bit patterns and pure fractions (truncation toward minus infinity)
        directed_rows.push_back(make_row(vec(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                             64'h5555_5555_5555_5555),
                                         vec(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                                             64'hAAAA_AAAA_AAAA_AAAA),
                                         vec(64'h0F0F_0F0F_F0F0_F0F0, 64'hF0F0_F0F0_0F0F_0F0F,
                                             64'h00FF_00FF_FF00_FF00), 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(vec(64'h0000_0000_8000_0001, '1, 64'h0000_0000_0000_0003),
                                         vec(64'hFFFF_FFFF_7FFF_FFFF, 64'h0000_0000_4000_0000, '1),
                                         vec(64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFF0,
                                             64'h0000_0000_C000_0000), 1'b1, 1'b0, '0));
        directed_rows.push_back(make_row(vec(MAX_Q, 0, 0), vec(0, MAX_Q, 0),
                                         vec(0, 0, MAX_Q), 1'b1, 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_face(directed_rows[i], $urandom_range(0, 9));
        end

        left_in_batch = 0;
        burst         = 1'b0;
        for (int n = 0; n < RANDOM_FACES; n++)
        begin
            if (n % 150 == 0)
            begin
                burst = ($urandom_range(0, 3) == 0);
            end
            if (left_in_batch == 0)
            begin
                left_in_batch = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 6);
            end
            left_in_batch--;
            gap = burst ? 0 : $urandom_range(0, 9);
            send_face(rand_face(left_in_batch == 0 || n == RANDOM_FACES - 1), gap);
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (pending_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d triangles in %0d batches, checked %0d batch sums",
                 faces_sent, batches_closed, sums_checked);
        $display("directed extremes, wrapping and degenerate faces, then random batches");
        if (error_count == 0)
        begin
            $display("signed_mesh_volume_accumulator regression: pass");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("signed_mesh_volume_accumulator regression: fail");
        end
        $finish;
    end

endmodule
